// File: hw/rtl/ransac_pose_inlier_select_top_defines.svh
// Assertion macros for the pose inlier selector.
// Uses the aclk and aresetn ports of the module that includes this header.
`ifndef RANSAC_POSE_INLIER_SELECT_TOP_DEFINES_SVH
`define RANSAC_POSE_INLIER_SELECT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPIS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPIS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rpis_pkg.sv
// Shared types, widths and codes for the pose inlier selector.
// No dependencies.
package rpis_pkg;

    localparam int MAX_POSES_DEF = 64;

    localparam int POS_W      = 24;
    localparam int YAW_W      = 16;
    localparam int POSE_W     = 3 * POS_W + YAW_W;
    localparam int THR_W      = 23;
    localparam int ATHR_W     = 15;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int DIFF_W     = POS_W;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int THR2_W     = 2 * THR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [THR_W-1:0]  POS_THR_RST = THR_W'(4096);
    localparam logic [ATHR_W-1:0] ANG_THR_RST = ATHR_W'(1430);

    typedef logic [CMD_W-1:0]     cmd_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cmd_t CMD_CLEAR = 2'd0;
    localparam cmd_t CMD_LOAD  = 2'd1;
    localparam cmd_t CMD_EVAL  = 2'd2;
    localparam cmd_t CMD_EMIT  = 2'd3;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_BAD_INDEX = 2'd2;
    localparam status_t ST_NO_BEST   = 2'd3;

    localparam cfg_idx_t REG_POS_THR = 2'd0;
    localparam cfg_idx_t REG_ANG_THR = 2'd1;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   inlier_count;
        logic               is_new_best;
        logic [CNT_W-1:0]   distance_rejects;
        logic [CNT_W-1:0]   angle_rejects;
        logic [CNT_W-1:0]   both_rejects;
        logic [IDX_W-1:0]   pose_index;
        logic               last;
    } res_t;

    function automatic logic [DIFF_W-1:0] pos_absdiff(input logic signed [POS_W-1:0] a,
                                                      input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic signed [POS_W:0] m;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        m = d[POS_W] ? -d : d;
        return m[DIFF_W-1:0];
    endfunction

    function automatic logic [YAW_W-1:0] yaw_absdiff(input logic signed [YAW_W-1:0] a,
                                                     input logic signed [YAW_W-1:0] b);
        logic signed [YAW_W:0] d;
        logic signed [YAW_W:0] m;
        d = {a[YAW_W-1], a} - {b[YAW_W-1], b};
        m = d[YAW_W] ? -d : d;
        return m[YAW_W-1:0];
    endfunction

endpackage

// File: hw/rtl/ransac_pose_inlier_select_top.sv
// Pose inlier selector: pose store, consensus scan with one shared squarer, best-set emit.
// Depends on rpis_pkg and ransac_pose_inlier_select_top_defines.svh.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | command, pos_x/y/z, heading, hypothesis_index
//   m_      | out       | m_valid / m_ready  | status, counts, is_new_best, pose_index, last
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (0 position, 1 angle)
//
// Clear, load and error results: registered from the execute state once m_ is free.
// Evaluate over N stored poses: each pose needs three passes through the
// single 24x24 squarer plus accumulate and compare.
// Emit: walks the pose slots up to the last inlier, holding on each inlier while m_ is not free.
// s_ready is high only between items; a result held by m_ready low stalls the sequencer.
// Synchronous active-low reset; the pose store itself is not cleared.
`include "ransac_pose_inlier_select_top_defines.svh"

module ransac_pose_inlier_select_top #(
    parameter int MAX_POSES = rpis_pkg::MAX_POSES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rpis_pkg::cmd_t                       s_command,
    input  logic signed [rpis_pkg::POS_W-1:0]    s_pos_x,
    input  logic signed [rpis_pkg::POS_W-1:0]    s_pos_y,
    input  logic signed [rpis_pkg::POS_W-1:0]    s_pos_z,
    input  logic signed [rpis_pkg::YAW_W-1:0]    s_heading,
    input  logic [rpis_pkg::IDX_W-1:0]           s_hypothesis_index,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rpis_pkg::status_t                    m_status,
    output logic [rpis_pkg::CNT_W-1:0]           m_inlier_count,
    output logic                                 m_is_new_best,
    output logic [rpis_pkg::CNT_W-1:0]           m_distance_rejects,
    output logic [rpis_pkg::CNT_W-1:0]           m_angle_rejects,
    output logic [rpis_pkg::CNT_W-1:0]           m_both_rejects,
    output logic [rpis_pkg::IDX_W-1:0]           m_pose_index,
    output logic                                 m_last,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  rpis_pkg::cfg_idx_t                   cfg_index,
    input  logic [rpis_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rpis_pkg::*;

    localparam int IW = $clog2(MAX_POSES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_HRD   = 4'd2;
    localparam logic [3:0] S_HLD   = 4'd3;
    localparam logic [3:0] S_THR   = 4'd4;
    localparam logic [3:0] S_DX    = 4'd5;
    localparam logic [3:0] S_DY    = 4'd6;
    localparam logic [3:0] S_DZ    = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_ACC   = 4'd9;
    localparam logic [3:0] S_CMP   = 4'd10;
    localparam logic [3:0] S_FETCH = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;
    localparam logic [3:0] S_EMIT  = 4'd13;

    // control state
    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      pose_count_reg, pose_count_next;
    logic                  best_valid_reg, best_valid_next;
    logic [MAX_POSES-1:0]  best_mask_reg, best_mask_next;
    logic [CNT_W-1:0]      best_count_reg, best_count_next;
    logic [THR_W-1:0]      pos_thr_reg, pos_thr_next;
    logic [ATHR_W-1:0]     ang_thr_reg, ang_thr_next;
    logic                  m_valid_reg, m_valid_next;

    // sequencer payload
    logic [IW-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      dr_reg, dr_next;
    logic [CNT_W-1:0]      ar_reg, ar_next;
    logic [CNT_W-1:0]      br_reg, br_next;
    logic [MAX_POSES-1:0]  mask_reg, mask_next;
    logic [MAX_POSES-1:0]  emit_mask_reg, emit_mask_next;
    logic [DIFF_W-1:0]     diff_reg, diff_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [THR2_W-1:0]     thr2_reg, thr2_next;
    logic                  ang_rej_reg, ang_rej_next;
    res_t                  res_reg, res_next;

    // latched command
    cmd_t                  cmd_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [YAW_W-1:0] yaw_in_reg;
    logic [IDX_W-1:0]      hyp_idx_reg;

    // hypothesis pose
    logic signed [POS_W-1:0] hx_reg, hy_reg, hz_reg;
    logic signed [YAW_W-1:0] hyaw_reg;

    // pose store
    logic [POSE_W-1:0]     pose_mem [MAX_POSES];
    logic [POSE_W-1:0]     rd_data_reg;
    logic                  mem_we;

    logic                  s_accept;
    logic                  out_free;
    logic                  push;
    logic [DIFF_W-1:0]     mul_a;
    logic                  dist_rej;
    logic                  new_best;
    logic signed [POS_W-1:0] rd_x, rd_y, rd_z;
    logic signed [YAW_W-1:0] rd_yaw;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign rd_x   = rd_data_reg[POSE_W-1 -: POS_W];
    assign rd_y   = rd_data_reg[POSE_W-1-POS_W -: POS_W];
    assign rd_z   = rd_data_reg[YAW_W+POS_W-1 -: POS_W];
    assign rd_yaw = rd_data_reg[YAW_W-1:0];

    // shared squarer operand: threshold once per evaluate, then pose deltas
    assign mul_a    = (state_reg == S_HLD) ? DIFF_W'(pos_thr_reg) : diff_reg;
    assign dist_rej = acc_reg > ACC_W'(thr2_reg);
    assign new_best = !best_valid_reg || (cnt_reg > best_count_reg);

    always_comb begin
        state_next      = state_reg;
        pose_count_next = pose_count_reg;
        best_valid_next = best_valid_reg;
        best_mask_next  = best_mask_reg;
        best_count_next = best_count_reg;
        pos_thr_next    = pos_thr_reg;
        ang_thr_next    = ang_thr_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        dr_next         = dr_reg;
        ar_next         = ar_reg;
        br_next         = br_reg;
        mask_next       = mask_reg;
        emit_mask_next  = emit_mask_reg;
        diff_next       = diff_reg;
        prod_next       = PROD_W'(mul_a * mul_a);
        acc_next        = acc_reg;
        thr2_next       = thr2_reg;
        ang_rej_next    = ang_rej_reg;
        mem_we          = 1'b0;
        push            = 1'b0;
        res_next        = '0;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_POS_THR: pos_thr_next = cfg_data[THR_W-1:0];
                REG_ANG_THR: ang_thr_next = cfg_data[ATHR_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (cmd_reg)
                    CMD_CLEAR: begin
                        if (out_free) begin
                            push            = 1'b1;
                            res_next.last   = 1'b1;
                            pose_count_next = '0;
                            best_valid_next = 1'b0;
                            best_mask_next  = '0;
                            best_count_next = '0;
                            state_next      = S_IDLE;
                        end
                    end
                    CMD_LOAD: begin
                        if (out_free) begin
                            push          = 1'b1;
                            res_next.last = 1'b1;
                            if (pose_count_reg >= CNT_W'(MAX_POSES)) begin
                                res_next.status = ST_FULL;
                            end else begin
                                mem_we          = 1'b1;
                                pose_count_next = pose_count_reg + 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_EVAL: begin
                        if (pose_count_reg == '0 || CNT_W'(hyp_idx_reg) >= pose_count_reg) begin
                            if (out_free) begin
                                push            = 1'b1;
                                res_next.status = ST_BAD_INDEX;
                                res_next.last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end else begin
                            idx_next   = hyp_idx_reg[IW-1:0];
                            state_next = S_HRD;
                        end
                    end
                    default: begin
                        if (!best_valid_reg || best_mask_reg == '0) begin
                            if (out_free) begin
                                push            = 1'b1;
                                res_next.status = ST_NO_BEST;
                                res_next.last   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end else begin
                            emit_mask_next = best_mask_reg;
                            idx_next       = '0;
                            state_next     = S_EMIT;
                        end
                    end
                endcase
            end
            S_HRD: begin
                state_next = S_HLD;
            end
            S_HLD: begin
                idx_next   = '0;
                cnt_next   = '0;
                dr_next    = '0;
                ar_next    = '0;
                br_next    = '0;
                mask_next  = '0;
                state_next = S_THR;
            end
            S_THR: begin
                thr2_next  = prod_reg[THR2_W-1:0];
                state_next = S_DX;
            end
            S_DX: begin
                diff_next  = pos_absdiff(rd_x, hx_reg);
                state_next = S_DY;
            end
            S_DY: begin
                diff_next  = pos_absdiff(rd_y, hy_reg);
                state_next = S_DZ;
            end
            S_DZ: begin
                acc_next   = ACC_W'(prod_reg);
                diff_next  = pos_absdiff(rd_z, hz_reg);
                state_next = S_SQ;
            end
            S_SQ: begin
                acc_next     = acc_reg + ACC_W'(prod_reg);
                ang_rej_next = yaw_absdiff(rd_yaw, hyaw_reg) > YAW_W'(ang_thr_reg);
                state_next   = S_ACC;
            end
            S_ACC: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = S_CMP;
            end
            S_CMP: begin
                if (dist_rej) begin
                    dr_next = dr_reg + 1'b1;
                end
                if (ang_rej_reg) begin
                    ar_next = ar_reg + 1'b1;
                end
                if (dist_rej && ang_rej_reg) begin
                    br_next = br_reg + 1'b1;
                end
                if (!dist_rej && !ang_rej_reg) begin
                    cnt_next  = cnt_reg + 1'b1;
                    mask_next = mask_reg | ({{(MAX_POSES-1){1'b0}}, 1'b1} << idx_reg);
                end
                if (CNT_W'(idx_reg) == pose_count_reg - 1'b1) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_DX;
            end
            S_DONE: begin
                if (out_free) begin
                    push                      = 1'b1;
                    res_next.inlier_count     = cnt_reg;
                    res_next.is_new_best      = new_best;
                    res_next.distance_rejects = dr_reg;
                    res_next.angle_rejects    = ar_reg;
                    res_next.both_rejects     = br_reg;
                    res_next.last             = 1'b1;
                    if (new_best) begin
                        best_valid_next = 1'b1;
                        best_mask_next  = mask_reg;
                        best_count_next = cnt_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_EMIT: begin
                // walk the best set one slot per cycle; hold on a set bit until m_ is free
                if (emit_mask_reg[0]) begin
                    if (out_free) begin
                        push                  = 1'b1;
                        res_next.inlier_count = best_count_reg;
                        res_next.pose_index   = IDX_W'(idx_reg);
                        res_next.last         = (emit_mask_reg[MAX_POSES-1:1] == '0);
                        emit_mask_next        = emit_mask_reg >> 1;
                        idx_next              = idx_reg + 1'b1;
                        if (emit_mask_reg[MAX_POSES-1:1] == '0) begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    emit_mask_next = emit_mask_reg >> 1;
                    idx_next       = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pose_count_reg <= '0;
            best_valid_reg <= 1'b0;
            best_mask_reg  <= '0;
            best_count_reg <= '0;
            pos_thr_reg    <= POS_THR_RST;
            ang_thr_reg    <= ANG_THR_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pose_count_reg <= pose_count_next;
            best_valid_reg <= best_valid_next;
            best_mask_reg  <= best_mask_next;
            best_count_reg <= best_count_next;
            pos_thr_reg    <= pos_thr_next;
            ang_thr_reg    <= ang_thr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        dr_reg        <= dr_next;
        ar_reg        <= ar_next;
        br_reg        <= br_next;
        mask_reg      <= mask_next;
        emit_mask_reg <= emit_mask_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        thr2_reg      <= thr2_next;
        ang_rej_reg   <= ang_rej_next;
        if (push) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg     <= s_command;
            px_reg      <= s_pos_x;
            py_reg      <= s_pos_y;
            pz_reg      <= s_pos_z;
            yaw_in_reg  <= s_heading;
            hyp_idx_reg <= s_hypothesis_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_HLD) begin
            hx_reg   <= rd_x;
            hy_reg   <= rd_y;
            hz_reg   <= rd_z;
            hyaw_reg <= rd_yaw;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pose_mem[pose_count_reg[IW-1:0]] <= {px_reg, py_reg, pz_reg, yaw_in_reg};
        end
        rd_data_reg <= pose_mem[idx_reg];
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = res_reg.status;
    assign m_inlier_count     = res_reg.inlier_count;
    assign m_is_new_best      = res_reg.is_new_best;
    assign m_distance_rejects = res_reg.distance_rejects;
    assign m_angle_rejects    = res_reg.angle_rejects;
    assign m_both_rejects     = res_reg.both_rejects;
    assign m_pose_index       = res_reg.pose_index;
    assign m_last             = res_reg.last;

    `RPIS_ASSERT_NXT(a_busy_after_transfer, s_valid && s_ready,
                     state_reg != S_IDLE,
                     "sequencer idle right after input transfer")
    `RPIS_ASSERT_IMP(a_scan_idx_in_store,
                     state_reg == S_THR || state_reg == S_DX || state_reg == S_DY ||
                     state_reg == S_DZ || state_reg == S_SQ || state_reg == S_ACC ||
                     state_reg == S_CMP || state_reg == S_FETCH,
                     CNT_W'(idx_reg) < pose_count_reg,
                     "scan index beyond stored poses")
    `RPIS_ASSERT_IMP(a_emit_mask_live, state_reg == S_EMIT,
                     emit_mask_reg != '0,
                     "emit walk with empty mask")
    `RPIS_ASSERT_NXT(a_best_after_eval, state_reg == S_DONE && out_free,
                     best_valid_reg && best_count_reg >= $past(cnt_reg),
                     "best set not updated after evaluate")
    `RPIS_ASSERT_NXT(a_clear_empties,
                     state_reg == S_EXEC && cmd_reg == CMD_CLEAR && out_free,
                     pose_count_reg == '0 && !best_valid_reg,
                     "clear left poses or best set")

endmodule
